// File: sv/rtfs_pkg.sv
// ----------------------------------------------------------------------------
// rtfs_pkg
// Shared types and constants for the RTF to plain text stripper.
// ----------------------------------------------------------------------------
package rtfs_pkg;

   localparam int unsigned MAX_NESTING = 255;
   localparam int unsigned DEPTH_W     = $clog2(MAX_NESTING + 1);

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NESTING);

   // character codes
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_P      = 8'h70;
   localparam logic [7:0] CH_A      = 8'h61;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_L      = 8'h6C;
   localparam logic [7:0] CH_I      = 8'h69;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_E      = 8'h65;

   typedef enum logic [2:0] {
      MODE_PLAIN = 3'b001,
      MODE_WORD  = 3'b010,
      MODE_HALT  = 3'b100
   } mode_type;

   typedef enum logic [3:0] {
      W_EMPTY = 4'd0,
      W_P     = 4'd1,
      W_PA    = 4'd2,
      W_PAR   = 4'd3,
      W_L     = 4'd4,
      W_LI    = 4'd5,
      W_LIN   = 4'd6,
      W_LINE  = 4'd7,
      W_OTHER = 4'd8
   } match_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_UNMATCHED  = 2'd1,
      ST_EOF_IN_CW  = 2'd2,
      ST_UNCLOSED   = 2'd3
   } status_type;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_EOF  = 1'b1;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_file;
      logic [1:0] status;
   } rsp_type;

endpackage

// File: sv/rtfs_scan.sv
// ----------------------------------------------------------------------------
// rtfs_scan
// Scanner state and the per-request update: brace depth, control word
// matching, error tracking and result generation.
// ----------------------------------------------------------------------------
module rtfs_scan (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic             kind,
   input  logic [7:0]       in_byte,
   output logic             emit,
   output rtfs_pkg::rsp_type result
);

   typedef struct packed {
      logic [rtfs_pkg::DEPTH_W-1:0] depth;
      logic [1:0]                   err;
      rtfs_pkg::mode_type           mode;
      logic                         emit;
      logic [7:0]                   data;
   } plain_type;

   logic [rtfs_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   rtfs_pkg::mode_type           mode_ff, mode_in;
   rtfs_pkg::match_type          match_ff, match_in;
   logic [1:0]                   err_ff, err_in;

   plain_type pl;
   logic      special;
   logic      space;
   logic      matched;
   logic      empty;

   function automatic plain_type scan_plain(
      input logic [7:0]                   b,
      input logic [rtfs_pkg::DEPTH_W-1:0] d,
      input logic [1:0]                   e
   );
      plain_type r;
      r.depth = d;
      r.err   = e;
      r.mode  = rtfs_pkg::MODE_PLAIN;
      r.emit  = 1'b0;
      r.data  = b;
      if (b == rtfs_pkg::CH_CR) begin
         r.emit = 1'b1;
         r.data = rtfs_pkg::CH_LF;
      end else if (b == rtfs_pkg::CH_LF) begin
         r.emit = 1'b0;
      end else if (b == rtfs_pkg::CH_LBRACE) begin
         if (d < rtfs_pkg::DEPTH_MAX) begin
            r.depth = d + 1'b1;
         end
      end else if (b == rtfs_pkg::CH_RBRACE) begin
         if (d == '0) begin
            if (e == rtfs_pkg::ST_OK) begin
               r.err = rtfs_pkg::ST_UNMATCHED;
            end
            r.mode = rtfs_pkg::MODE_HALT;
         end else begin
            r.depth = d - 1'b1;
         end
      end else if (d > rtfs_pkg::DEPTH_W'(1)) begin
         r.emit = 1'b0;
      end else if (b == rtfs_pkg::CH_BSLASH) begin
         r.mode = rtfs_pkg::MODE_WORD;
      end else begin
         r.emit = 1'b1;
      end
      return r;
   endfunction

   function automatic rtfs_pkg::match_type next_match(
      input rtfs_pkg::match_type m,
      input logic [7:0]          b
   );
      rtfs_pkg::match_type n;
      n = rtfs_pkg::W_OTHER;
      case (m)
         rtfs_pkg::W_EMPTY: begin
            if (b == rtfs_pkg::CH_P) n = rtfs_pkg::W_P;
            else if (b == rtfs_pkg::CH_L) n = rtfs_pkg::W_L;
         end
         rtfs_pkg::W_P:   if (b == rtfs_pkg::CH_A) n = rtfs_pkg::W_PA;
         rtfs_pkg::W_PA:  if (b == rtfs_pkg::CH_R) n = rtfs_pkg::W_PAR;
         rtfs_pkg::W_L:   if (b == rtfs_pkg::CH_I) n = rtfs_pkg::W_LI;
         rtfs_pkg::W_LI:  if (b == rtfs_pkg::CH_N) n = rtfs_pkg::W_LIN;
         rtfs_pkg::W_LIN: if (b == rtfs_pkg::CH_E) n = rtfs_pkg::W_LINE;
         default:         n = rtfs_pkg::W_OTHER;
      endcase
      return n;
   endfunction

   assign pl      = scan_plain(in_byte, depth_ff, err_ff);
   assign special = (in_byte == rtfs_pkg::CH_BSLASH) || (in_byte == rtfs_pkg::CH_LBRACE) ||
                    (in_byte == rtfs_pkg::CH_RBRACE) || (in_byte == rtfs_pkg::CH_LF);
   assign space   = (in_byte == rtfs_pkg::CH_SPACE) ||
                    ((in_byte >= rtfs_pkg::CH_TAB) && (in_byte <= rtfs_pkg::CH_CR));
   assign matched = (match_ff == rtfs_pkg::W_PAR) || (match_ff == rtfs_pkg::W_LINE);
   assign empty   = (match_ff == rtfs_pkg::W_EMPTY);

   always_comb begin
      depth_in           = depth_ff;
      mode_in            = mode_ff;
      match_in           = match_ff;
      err_in             = err_ff;
      emit               = 1'b0;
      result.out_byte    = 8'h00;
      result.end_of_file = 1'b0;
      result.status      = rtfs_pkg::ST_OK;
      if (kind == rtfs_pkg::KIND_EOF) begin
         emit               = 1'b1;
         result.end_of_file = 1'b1;
         if (err_ff != rtfs_pkg::ST_OK) result.status = err_ff;
         else if (mode_ff == rtfs_pkg::MODE_WORD) result.status = rtfs_pkg::ST_EOF_IN_CW;
         else if (depth_ff != '0) result.status = rtfs_pkg::ST_UNCLOSED;
         depth_in = '0;
         mode_in  = rtfs_pkg::MODE_PLAIN;
         match_in = rtfs_pkg::W_EMPTY;
         err_in   = rtfs_pkg::ST_OK;
      end else begin
         unique case (mode_ff)
            rtfs_pkg::MODE_HALT: begin
               emit = 1'b0;
            end
            rtfs_pkg::MODE_WORD: begin
               if (special || space) begin
                  mode_in  = rtfs_pkg::MODE_PLAIN;
                  match_in = rtfs_pkg::W_EMPTY;
                  if (special && empty) begin
                     emit            = 1'b1;
                     result.out_byte = in_byte;
                  end else begin
                     if (matched) begin
                        emit            = 1'b1;
                        result.out_byte = rtfs_pkg::CH_LF;
                     end
                     // terminating brace or backslash is rescanned as plain
                     if (special && (in_byte != rtfs_pkg::CH_LF)) begin
                        depth_in = pl.depth;
                        err_in   = pl.err;
                        mode_in  = pl.mode;
                     end
                  end
               end else begin
                  match_in = next_match(match_ff, in_byte);
               end
            end
            default: begin
               depth_in = pl.depth;
               err_in   = pl.err;
               mode_in  = pl.mode;
               if (pl.mode == rtfs_pkg::MODE_WORD) match_in = rtfs_pkg::W_EMPTY;
               emit            = pl.emit;
               result.out_byte = pl.data;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         mode_ff  <= rtfs_pkg::MODE_PLAIN;
         match_ff <= rtfs_pkg::W_EMPTY;
         err_ff   <= rtfs_pkg::ST_OK;
      end else if (take) begin
         depth_ff <= depth_in;
         mode_ff  <= mode_in;
         match_ff <= match_in;
         err_ff   <= err_in;
      end
   end

endmodule

// File: sv/rtfs_out_buf.sv
// ----------------------------------------------------------------------------
// rtfs_out_buf
// Two-entry result queue; keeps the request side open while a result waits.
// ----------------------------------------------------------------------------
module rtfs_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rtfs_pkg::rsp_type push_data,
   output logic              has_room,
   output logic              out_valid,
   input  logic              out_ready,
   output rtfs_pkg::rsp_type out_data
);

   rtfs_pkg::rsp_type slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign has_room  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/rtf_to_text_stripper.sv
// ----------------------------------------------------------------------------
// rtf_to_text_stripper
// RTF to plain text, one byte per request; end request returns file status.
// ----------------------------------------------------------------------------
//   channel | direction | fields
//   req     | in        | kind, in_byte
//   rsp     | out       | out_byte, end_of_file, status
//
// One request per cycle while req_ready is high; the scanner updates depth, mode
// and word match on acceptance, and any result is registered in the queue.
// A two-entry result queue lets requests flow while a result is stalled;
// req_ready drops only when both entries are occupied.
// Synchronous active-high reset returns the scanner to plain text, depth 0.
// ----------------------------------------------------------------------------
module rtf_to_text_stripper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_end_of_file,
   output logic [1:0] rsp_status
);

   logic              take;
   logic              emit;
   logic              has_room;
   rtfs_pkg::rsp_type result;
   rtfs_pkg::rsp_type head;

   assign req_ready = has_room;
   assign take      = req_valid && has_room;

   rtfs_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .kind    (req_kind),
      .in_byte (req_in_byte),
      .emit    (emit),
      .result  (result)
   );

   rtfs_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (take && emit),
      .push_data (result),
      .has_room  (has_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (head)
   );

   assign rsp_out_byte    = head.out_byte;
   assign rsp_end_of_file = head.end_of_file;
   assign rsp_status      = head.status;

endmodule
